[rtl/cotm_pkg.sv]
// Shared types and constants for the clock-offset trimmed-mean block.
// Used by cotm_ctrl, cotm_dp and clock_offset_trimmed_mean. No dependencies.
package cotm_pkg;

    // Sample and configuration widths
    localparam int SAMPLE_W = 32;
    localparam int FAIL_W   = 3;
    localparam logic [FAIL_W-1:0] FAIL_LIMIT_RESET = 3'd3;

    // Sum bits taken per reciprocal-multiply step
    localparam int DIV_CHUNK_W = 12;

    // Controller to datapath commands
    typedef struct packed {
        logic store_wr;     // write incoming sample at the fill index
        logic acc_clear;    // zero the accumulator
        logic sort_step;    // one odd-even transposition pass
        logic sort_odd;     // pass compares odd pairs
        logic sum_step;     // rotate the store by one entry
        logic sum_add;      // add entry 0 into the accumulator
        logic div_load;     // load sum magnitude into the reciprocal multiply
        logic div_step;     // multiply one chunk of the magnitude
        logic out_plain;    // load a result with no average
        logic out_abandon;  // plain result ends the round
        logic out_avg;      // load the averaged result
    } cotm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sample_zero;  // incoming sample is a timeout
    } cotm_stat_t;

endpackage

[rtl/cotm_dp.sv]
// Datapath: sample store with odd-even transposition sort, rotating
// accumulator, reciprocal-multiply divider and result register. Depends on cotm_pkg.
module cotm_dp #(
    parameter int SAMPLES_REQUIRED = 8,
    parameter int EFF_USED         = 4,
    parameter int IDX_W            = 3,
    parameter int ACC_W            = 35,
    parameter int DIV_STEPS        = 3
) (
    input  logic                              clk,
    input  cotm_pkg::cotm_cmd_t               cmd,
    input  logic [IDX_W-1:0]                  wr_idx,
    input  logic [cotm_pkg::SAMPLE_W-1:0]     sample,
    output cotm_pkg::cotm_stat_t              stat,
    output logic                              round_done,
    output logic                              average_valid,
    output logic [cotm_pkg::SAMPLE_W-1:0]     averaged_offset
);
    import cotm_pkg::*;

    // Rounded-up reciprocal of the kept count; exact below 2**PAD_W
    localparam int     PAD_W     = DIV_STEPS * DIV_CHUNK_W;
    localparam int     POST_SH   = $clog2(EFF_USED);
    localparam int     RECIP_W   = PAD_W + 1;
    localparam int     PROD_W    = RECIP_W + DIV_CHUNK_W;
    localparam longint RECIP_VAL = ((longint'(1) << (PAD_W + POST_SH))
                                    + longint'(EFF_USED) - 1) / longint'(EFF_USED);
    localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_VAL);

    logic signed [SAMPLE_W-1:0] store_reg  [SAMPLES_REQUIRED];
    logic signed [SAMPLE_W-1:0] store_next [SAMPLES_REQUIRED];
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic [ACC_W-1:0]           acc_mag;
    logic                       neg_reg;
    logic [PAD_W-1:0]           mag_reg;
    logic [PAD_W-1:0]           mag_next;
    logic [RECIP_W-1:0]         prod_reg;
    logic [RECIP_W-1:0]         prod_next;
    logic [PROD_W-1:0]          partial;
    logic [PROD_W-1:0]          prod_sum;
    logic [RECIP_W-1:0]         quo_mag;
    logic [SAMPLE_W-1:0]        quo_low;
    logic [SAMPLE_W-1:0]        quo_signed;
    logic                       done_reg;
    logic                       avg_valid_reg;
    logic [SAMPLE_W-1:0]        avg_reg;

    assign stat.sample_zero = (sample == '0);

    // Store update: sample write, sort pass or rotation
    always_comb
    begin
        store_next = store_reg;
        if (cmd.store_wr)
        begin
            store_next[wr_idx] = sample;
        end
        else if (cmd.sort_step)
        begin
            for (int i = 0; i < SAMPLES_REQUIRED - 1; i++)
            begin
                if ((i[0] == cmd.sort_odd) && (store_reg[i] > store_reg[i+1]))
                begin
                    store_next[i]   = store_reg[i+1];
                    store_next[i+1] = store_reg[i];
                end
            end
        end
        else if (cmd.sum_step)
        begin
            for (int i = 0; i < SAMPLES_REQUIRED - 1; i++)
            begin
                store_next[i] = store_reg[i+1];
            end
            store_next[SAMPLES_REQUIRED-1] = store_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    // Accumulator over the kept window
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clear)
        begin
            acc_next = '0;
        end
        else if (cmd.sum_step && cmd.sum_add)
        begin
            acc_next = acc_reg + {{(ACC_W-SAMPLE_W){store_reg[0][SAMPLE_W-1]}}, store_reg[0]};
        end
    end

    // Divide the magnitude by the kept count: multiply by the reciprocal one
    // chunk at a time from the low end, dropping a chunk of fraction each step
    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign partial  = RECIP * PROD_W'(mag_reg[DIV_CHUNK_W-1:0]);
    assign prod_sum = PROD_W'(prod_reg) + partial;

    always_comb
    begin
        mag_next  = mag_reg;
        prod_next = prod_reg;
        if (cmd.div_load)
        begin
            mag_next  = PAD_W'(acc_mag);
            prod_next = '0;
        end
        else if (cmd.div_step)
        begin
            mag_next  = mag_reg >> DIV_CHUNK_W;
            prod_next = prod_sum[PROD_W-1:DIV_CHUNK_W];
        end
    end

    // Remaining shift gives the truncated quotient; sign restored after
    assign quo_mag    = prod_reg >> POST_SH;
    assign quo_low    = quo_mag[SAMPLE_W-1:0];
    assign quo_signed = neg_reg ? (~quo_low + 1'b1) : quo_low;

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        if (cmd.div_load)
        begin
            neg_reg <= acc_reg[ACC_W-1];
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_plain)
        begin
            done_reg      <= cmd.out_abandon;
            avg_valid_reg <= 1'b0;
            avg_reg       <= '0;
        end
        else if (cmd.out_avg)
        begin
            done_reg      <= 1'b1;
            avg_valid_reg <= 1'b1;
            avg_reg       <= quo_signed;
        end
    end

    assign round_done      = done_reg;
    assign average_valid   = avg_valid_reg;
    assign averaged_offset = avg_reg;

endmodule

[rtl/cotm_ctrl.sv]
// Controller: round bookkeeping, timeout counting and the sort/sum/divide
// sequence. Drives the stream handshakes. Depends on cotm_pkg.
module cotm_ctrl #(
    parameter int SAMPLES_REQUIRED = 8,
    parameter int EFF_USED         = 4,
    parameter int TRIM             = 2,
    parameter int DIV_STEPS        = 3,
    parameter int IDX_W            = 3,
    parameter int STEP_W           = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cotm_pkg::FAIL_W-1:0]   cfg_data,
    input  cotm_pkg::cotm_stat_t          stat,
    output cotm_pkg::cotm_cmd_t           cmd,
    output logic [IDX_W-1:0]              wr_idx
);
    import cotm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SORT  = 6'b000010,
        ST_SUM   = 6'b000100,
        ST_DIVLD = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]    count_reg, count_next;
    logic [FAIL_W-1:0]   timeout_reg, timeout_next;
    logic [FAIL_W-1:0]   timeout_inc;
    logic [FAIL_W-1:0]   fail_limit_reg;
    logic                out_valid_reg, out_valid_next;
    logic                accept;

    assign cfg_ready   = 1'b1;
    assign s_tready    = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept      = s_tvalid && s_tready;
    assign m_tvalid    = out_valid_reg;
    assign wr_idx      = count_reg;
    assign timeout_inc = timeout_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        timeout_next = timeout_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (stat.sample_zero)
                    begin
                        cmd.out_plain = 1'b1;
                        if (timeout_inc == fail_limit_reg)
                        begin
                            timeout_next    = '0;
                            count_next      = '0;
                            cmd.out_abandon = 1'b1;
                        end
                        else
                        begin
                            timeout_next = timeout_inc;
                        end
                    end
                    else
                    begin
                        cmd.store_wr = 1'b1;
                        if (count_reg == IDX_W'(SAMPLES_REQUIRED - 1))
                        begin
                            count_next    = '0;
                            cmd.acc_clear = 1'b1;
                            step_next     = '0;
                            state_next    = ST_SORT;
                        end
                        else
                        begin
                            count_next    = count_reg + 1'b1;
                            cmd.out_plain = 1'b1;
                        end
                    end
                end
            end
            ST_SORT:
            begin
                cmd.sort_step = 1'b1;
                cmd.sort_odd  = step_reg[0];
                if (step_reg == STEP_W'(SAMPLES_REQUIRED - 1))
                begin
                    step_next  = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                cmd.sum_add  = (step_reg >= STEP_W'(TRIM));
                if (step_reg == STEP_W'(TRIM + EFF_USED - 1))
                begin
                    step_next  = '0;
                    state_next = ST_DIVLD;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIVLD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                cmd.out_avg = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_plain || cmd.out_avg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            count_reg      <= '0;
            timeout_reg    <= '0;
            fail_limit_reg <= FAIL_LIMIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            timeout_reg   <= timeout_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                fail_limit_reg <= cfg_data;
            end
        end
    end

endmodule

[rtl/clock_offset_trimmed_mean.sv]
// Clock-offset trimmed-mean averager, top level.
// Instantiates cotm_ctrl and cotm_dp. Depends on cotm_pkg.
//
// Usage:
//   s_* stream carries one signed 32-bit offset sample per transaction;
//   zero marks a timeout. Every sample yields exactly one result on m_*:
//   m_tlast = round finished, m_tuser = average present, m_tdata = mean.
//   cfg_* writes the 3-bit failure limit (reset value 3); cfg_ready is
//   always high. Write it only while no sample is in flight.
// Sequencing:
//   A sample that does not complete the store gives its result in the cycle
//   after acceptance. The sample that fills the store starts the round end:
//   SAMPLES_REQUIRED odd-even sort passes, trim + used rotate/add steps, one
//   divider load, a reciprocal multiply taking the sum 12 bits a cycle and
//   one result load.
//   One sample is in work at a time; s_tready is high only in idle.
// Reset and stall:
//   rst_n clears counts, failure limit and the output slot; the sample
//   store is not cleared. While m_tready is low the result holds and no
//   new sample is taken until the slot drains.
module clock_offset_trimmed_mean #(
    parameter int SAMPLES_REQUIRED = 8,
    parameter int SAMPLES_USED     = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cotm_pkg::SAMPLE_W-1:0] s_tdata,   // [31:0] offset_sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cotm_pkg::SAMPLE_W-1:0] m_tdata,   // [31:0] averaged_offset
    output logic                          m_tlast,   // round_done
    output logic                          m_tuser,   // [0] average_valid
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cotm_pkg::FAIL_W-1:0]   cfg_data   // [2:0] fail_limit
);
    import cotm_pkg::*;

    localparam int EFF_USED  = (SAMPLES_USED < SAMPLES_REQUIRED) ?
                               SAMPLES_USED : SAMPLES_REQUIRED;
    localparam int TRIM      = (SAMPLES_REQUIRED - EFF_USED) / 2;
    localparam int IDX_W     = $clog2(SAMPLES_REQUIRED);
    localparam int ACC_W     = SAMPLE_W + $clog2(SAMPLES_REQUIRED);
    localparam int DIV_STEPS = (ACC_W + DIV_CHUNK_W - 1) / DIV_CHUNK_W;
    localparam int STEP_W    = $clog2(SAMPLES_REQUIRED + 1);

    cotm_cmd_t          cmd;
    cotm_stat_t         stat;
    logic [IDX_W-1:0]   wr_idx;

    cotm_ctrl #(
        .SAMPLES_REQUIRED (SAMPLES_REQUIRED),
        .EFF_USED         (EFF_USED),
        .TRIM             (TRIM),
        .DIV_STEPS        (DIV_STEPS),
        .IDX_W            (IDX_W),
        .STEP_W           (STEP_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd),
        .wr_idx    (wr_idx)
    );

    cotm_dp #(
        .SAMPLES_REQUIRED (SAMPLES_REQUIRED),
        .EFF_USED         (EFF_USED),
        .IDX_W            (IDX_W),
        .ACC_W            (ACC_W),
        .DIV_STEPS        (DIV_STEPS)
    ) u_dp (
        .clk             (clk),
        .cmd             (cmd),
        .wr_idx          (wr_idx),
        .sample          (s_tdata),
        .stat            (stat),
        .round_done      (m_tlast),
        .average_valid   (m_tuser),
        .averaged_offset (m_tdata)
    );

endmodule
